// ----- rtl/core/lcsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcsd_pkg
// Shared types and constants for the display command stream decoder.
// ---------------------------------------------------------------------------
package lcsd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COLUMN_W   = 5;
    localparam int unsigned LINE_W     = 3;
    localparam int unsigned GLYPH_IDX_W = 4;

    // command bytes
    localparam logic [BYTE_W-1:0] CMD_GOTO       = 8'h11;
    localparam logic [BYTE_W-1:0] CMD_LIGHT      = 8'h12;
    localparam logic [BYTE_W-1:0] CMD_GLYPH      = 8'h13;
    localparam logic [BYTE_W-1:0] CMD_CLEAR      = 8'h14;
    // printable ranges: below PRINT_LO_END, or PRINT_HI_START and up
    localparam logic [BYTE_W-1:0] PRINT_LO_END   = 8'h10;
    localparam logic [BYTE_W-1:0] PRINT_HI_START = 8'h20;

    // glyph: slot byte plus eight rows
    localparam int unsigned GLYPH_BYTES = 9;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_FIRST_ROW = 4'd1;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_LAST      = 4'd8;

    typedef enum logic [2:0] {
        OP_PUTC      = 3'd0,
        OP_GOTO      = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_BACKLIGHT = 3'd3,
        OP_SLOT      = 3'd4,
        OP_ROW       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_GOTO  = 2'd1,
        PEND_LIGHT = 2'd2,
        PEND_GLYPH = 2'd3
    } t_pend;

    typedef struct packed {
        t_op                 op;
        logic [BYTE_W-1:0]   value;
        logic [COLUMN_W-1:0] column;
        logic [LINE_W-1:0]   line;
        logic                last;
    } t_result;

    // width of packed op/value/column/line, and padded to whole bytes
    localparam int unsigned RES_W   = 3 + BYTE_W + COLUMN_W + LINE_W;
    localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage : lcsd_pkg
`default_nettype wire

// ----- rtl/core/lcsd_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcsd_in_reg
// Input word register; refills in the cycle the decoder takes its word.
// ---------------------------------------------------------------------------
module lcsd_in_reg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [lcsd_pkg::BYTE_W-1:0] i_data,
    output logic                            o_valid,
    input  wire logic                       i_take,
    output logic [lcsd_pkg::BYTE_W-1:0]     o_data
);
    import lcsd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule : lcsd_in_reg
`default_nettype wire

// ----- rtl/core/lcsd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcsd_decode
// Command decode, argument capture, glyph store and glyph row burst.
// ---------------------------------------------------------------------------
module lcsd_decode (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [lcsd_pkg::BYTE_W-1:0] i_in_byte,
    output logic                             o_in_take,
    input  wire logic                        i_res_ready,
    output logic                             o_res_valid,
    output lcsd_pkg::t_result                o_res
);
    import lcsd_pkg::*;

    t_pend                  r_pend, n_pend;
    logic [GLYPH_IDX_W-1:0] r_count, n_count;
    logic                   r_burst, n_burst;
    logic [GLYPH_IDX_W-1:0] r_idx, n_idx;
    logic                   wr_en;

    logic [BYTE_W-1:0] glyph_store [GLYPH_BYTES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= PEND_NONE;
            r_count <= '0;
            r_burst <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_pend  <= n_pend;
            r_count <= n_count;
            r_burst <= n_burst;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            glyph_store[r_count] <= i_in_byte;
        end
    end

    always_comb begin
        n_pend      = r_pend;
        n_count     = r_count;
        n_burst     = r_burst;
        n_idx       = r_idx;
        o_in_take   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        wr_en       = 1'b0;

        if (r_burst) begin
            // drain glyph rows; input waits
            o_res_valid = 1'b1;
            o_res.op    = OP_ROW;
            o_res.value = glyph_store[r_idx];
            o_res.last  = (r_idx == GLYPH_LAST);
            if (i_res_ready) begin
                n_idx = r_idx + GLYPH_FIRST_ROW;
                if (r_idx == GLYPH_LAST) begin
                    n_burst = 1'b0;
                end
            end
        end else if (i_in_valid) begin
            case (r_pend)
                PEND_GOTO: begin
                    o_res_valid  = 1'b1;
                    o_res.op     = OP_GOTO;
                    o_res.column = i_in_byte[COLUMN_W-1:0];
                    o_res.line   = i_in_byte[BYTE_W-1:COLUMN_W];
                    o_res.last   = 1'b1;
                    o_in_take    = i_res_ready;
                    if (i_res_ready) begin
                        n_pend = PEND_NONE;
                    end
                end
                PEND_LIGHT: begin
                    o_res_valid = 1'b1;
                    o_res.op    = OP_BACKLIGHT;
                    o_res.value = i_in_byte;
                    o_res.last  = 1'b1;
                    o_in_take   = i_res_ready;
                    if (i_res_ready) begin
                        n_pend = PEND_NONE;
                    end
                end
                PEND_GLYPH: begin
                    if (r_count == GLYPH_LAST) begin
                        // ninth byte: slot select now, rows follow
                        o_res_valid = 1'b1;
                        o_res.op    = OP_SLOT;
                        o_res.line  = glyph_store[0][LINE_W-1:0];
                        o_in_take   = i_res_ready;
                        wr_en       = i_res_ready;
                        if (i_res_ready) begin
                            n_count = '0;
                            n_pend  = PEND_NONE;
                            n_burst = 1'b1;
                            n_idx   = GLYPH_FIRST_ROW;
                        end
                    end else begin
                        o_in_take = 1'b1;
                        wr_en     = 1'b1;
                        n_count   = r_count + GLYPH_FIRST_ROW;
                    end
                end
                default: begin
                    if (i_in_byte >= PRINT_HI_START || i_in_byte < PRINT_LO_END) begin
                        o_res_valid = 1'b1;
                        o_res.op    = OP_PUTC;
                        o_res.value = i_in_byte;
                        o_res.last  = 1'b1;
                        o_in_take   = i_res_ready;
                    end else if (i_in_byte == CMD_CLEAR) begin
                        o_res_valid = 1'b1;
                        o_res.op    = OP_CLEAR;
                        o_res.last  = 1'b1;
                        o_in_take   = i_res_ready;
                    end else begin
                        o_in_take = 1'b1;
                        if (i_in_byte == CMD_GOTO) begin
                            n_pend = PEND_GOTO;
                        end else if (i_in_byte == CMD_LIGHT) begin
                            n_pend = PEND_LIGHT;
                        end else if (i_in_byte == CMD_GLYPH) begin
                            n_pend = PEND_GLYPH;
                        end
                    end
                end
            endcase
        end
    end

endmodule : lcsd_decode
`default_nettype wire

// ----- rtl/core/lcsd_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcsd_out_reg
// Result register; loads whenever empty or being drained.
// ---------------------------------------------------------------------------
module lcsd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire lcsd_pkg::t_result i_res,
    output logic                   o_res_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output lcsd_pkg::t_result      o_res
);
    import lcsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule : lcsd_out_reg
`default_nettype wire

// ----- rtl/core/lcd_command_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcd_command_stream_decoder_unit
// Turns a received byte stream into character-display operations.
// ---------------------------------------------------------------------------
//  channel   | dir | tdata                                 | tlast
//  s_axis    | in  | [7:0] rx_byte                         | -
//  m_axis    | out | [2:0] op [10:3] value [15:11] column  | last
//            |     | [18:16] line, [23:19] zero            |
//
//  One word per cycle unless m_axis stalls or a glyph drains:
//  input register -> decode -> result register; a result word
//  reaches m_axis through both registers. A completed glyph gives
//  nine result words that the glyph store read port drains; input
//  waits meanwhile. Synchronous active-low reset clears pending
//  command, glyph count, row burst and both valid flags. Stalls on
//  m_axis back up through the result register into the input
//  register; one input word is held while a result waits.
// ---------------------------------------------------------------------------
module lcd_command_stream_decoder_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [lcsd_pkg::TDATA_W-1:0]      m_axis_tdata,   // op, value, column, line
    output logic                              m_axis_tlast    // last
);
    import lcsd_pkg::*;

    logic              in_valid;
    logic              in_take;
    logic [BYTE_W-1:0] in_byte;
    logic              res_valid;
    logic              res_ready;
    t_result           res;
    t_result           out_res;

    lcsd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (in_valid),
        .i_take  (in_take),
        .o_data  (in_byte)
    );

    lcsd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_byte   (in_byte),
        .o_in_take   (in_take),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lcsd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (out_res)
    );

    // pack op lowest, then value, column, line; pad with zeros
    assign m_axis_tdata = {{(TDATA_W-RES_W){1'b0}}, out_res.line, out_res.column,
                           out_res.value, out_res.op};
    assign m_axis_tlast = out_res.last;

endmodule : lcd_command_stream_decoder_unit
`default_nettype wire
